FILE: rtl/core/fpba_pkg.sv
package fpba_pkg;

  localparam int unsigned DW = 13;
  localparam int unsigned AWF = 12;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_BADFREE = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_ARENA  = 1'b1;

  localparam int unsigned DEF_ARENA_BYTES  = 4096;
  localparam int unsigned DEF_HEADER_BYTES = 32;
  localparam int unsigned DEF_MAX_BLOCKS   = 128;
  localparam int unsigned ARENA_RST        = 4096;
  localparam int unsigned ARENA_MIN        = 64;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_ALLOC,
    OP_FREE,
    OP_MERGE
  } op_e;

  typedef struct packed {
    logic          v;
    logic          free;
    logic [DW-1:0] off;
    logic [DW-1:0] size;
  } ent_t;

  typedef struct packed {
    op_e           op;
    logic [DW-1:0] need;
    logic          split;
    logic          merge;
    logic [DW-1:0] init_size;
  } cmd_t;

  typedef struct packed {
    logic           mode_free;
    logic [1:0]     policy;
    logic [DW:0]    need;
    logic [AWF-1:0] addr;
  } srch_t;

  typedef struct packed {
    logic          v;
    logic          free;
    logic          nf;
    logic          pf;
    logic [DW-1:0] off;
    logic [DW-1:0] size;
  } cand_t;

endpackage

FILE: rtl/core/fpba_cell.sv
module fpba_cell #(
  parameter int unsigned IW           = 7,
  parameter int unsigned J            = 0,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned RST_SIZE     = 4064
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpba_pkg::cmd_t    cmd_i,
  input  logic [IW-1:0]     idx_i,
  input  fpba_pkg::srch_t   srch_i,
  input  fpba_pkg::ent_t    left_i,
  input  fpba_pkg::ent_t    right_i,
  output fpba_pkg::ent_t    ent_o,
  input  fpba_pkg::cand_t   cand_i,
  input  logic [IW-1:0]     cand_idx_i,
  output fpba_pkg::cand_t   cand_o,
  output logic [IW-1:0]     cand_idx_o
);
  import fpba_pkg::*;

  localparam logic [DW-1:0] HDR = DW'(HEADER_BYTES);
  localparam logic [IW:0]   JV  = (IW+1)'(J);

  ent_t          ent_q, ent_d;
  cand_t         cand_q, cand_d;
  logic [IW-1:0] cidx_q, cidx_d;
  logic [IW:0]   idx_x, idx_p1;
  logic [DW:0]   data_off;
  logic          elig_a, elig_f, take;

  assign idx_x  = {1'b0, idx_i};
  assign idx_p1 = idx_x + 1'b1;

  always_comb begin
    ent_d = ent_q;
    case (cmd_i.op)
      OP_INIT: begin
        ent_d.v    = (J == 0);
        ent_d.off  = '0;
        ent_d.size = cmd_i.init_size;
        ent_d.free = 1'b1;
      end
      OP_ALLOC: begin
        if (JV == idx_x) begin
          ent_d.free = 1'b0;
          if (cmd_i.split) ent_d.size = cmd_i.need;
        end else if (cmd_i.split && JV == idx_p1) begin
          ent_d.v    = 1'b1;
          ent_d.free = 1'b1;
          ent_d.off  = left_i.off + HDR + cmd_i.need;
          ent_d.size = left_i.size - cmd_i.need - HDR;
        end else if (cmd_i.split && JV > idx_p1) begin
          ent_d = left_i;
        end
      end
      OP_FREE: begin
        if (JV == idx_x) begin
          ent_d.free = 1'b1;
          if (cmd_i.merge) ent_d.size = ent_q.size + HDR + right_i.size;
        end else if (cmd_i.merge && JV > idx_x) begin
          ent_d = right_i;
        end
      end
      OP_MERGE: begin
        if (JV + 1'b1 == idx_x) begin
          ent_d.size = ent_q.size + HDR + right_i.size;
        end else if (JV >= idx_x) begin
          ent_d = right_i;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    data_off = {1'b0, ent_q.off} + {1'b0, HDR};
    elig_f   = ent_q.v && (data_off == {2'b00, srch_i.addr});
    elig_a   = ent_q.v && ent_q.free && ({1'b0, ent_q.size} >= srch_i.need);
    take     = 1'b0;
    if (srch_i.mode_free) begin
      take = elig_f;
    end else begin
      case (srch_i.policy)
        FIT_FIRST: take = elig_a && !cand_i.v;
        FIT_BEST:  take = elig_a && (!cand_i.v || ent_q.size < cand_i.size);
        FIT_WORST: take = elig_a && (!cand_i.v || ent_q.size > cand_i.size);
        default:   take = 1'b0;
      endcase
    end
    if (take) begin
      cand_d.v    = 1'b1;
      cand_d.free = ent_q.free;
      cand_d.nf   = right_i.v && right_i.free;
      cand_d.pf   = left_i.v && left_i.free;
      cand_d.off  = ent_q.off;
      cand_d.size = ent_q.size;
      cidx_d      = IW'(J);
    end else begin
      cand_d = cand_i;
      cidx_d = cand_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.v    <= (J == 0);
      ent_q.free <= 1'b1;
      ent_q.off  <= '0;
      ent_q.size <= DW'(RST_SIZE);
    end else begin
      ent_q <= ent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    cidx_q <= cidx_d;
  end

  assign ent_o      = ent_q;
  assign cand_o     = cand_q;
  assign cand_idx_o = cidx_q;

endmodule

FILE: rtl/core/fpba_chain.sv
module fpba_chain #(
  parameter int unsigned MAX_BLOCKS   = 128,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned RST_SIZE     = 4064,
  parameter int unsigned IW           = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fpba_pkg::cmd_t   cmd_i,
  input  logic [IW-1:0]    idx_i,
  input  fpba_pkg::srch_t  srch_i,
  output fpba_pkg::cand_t  cand_o,
  output logic [IW-1:0]    cand_idx_o
);
  import fpba_pkg::*;

  ent_t          ent   [MAX_BLOCKS];
  cand_t         cand  [MAX_BLOCKS];
  logic [IW-1:0] cidx  [MAX_BLOCKS];

  for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
    ent_t          left_w, right_w;
    cand_t         cin_w;
    logic [IW-1:0] ciin_w;

    if (j == 0) begin : g_first
      assign left_w = '0;
      assign cin_w  = '0;
      assign ciin_w = '0;
    end else begin : g_mid
      assign left_w = ent[j-1];
      assign cin_w  = cand[j-1];
      assign ciin_w = cidx[j-1];
    end

    if (j == MAX_BLOCKS - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = ent[j+1];
    end

    fpba_cell #(
      .IW           (IW),
      .J            (j),
      .HEADER_BYTES (HEADER_BYTES),
      .RST_SIZE     (RST_SIZE)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd_i),
      .idx_i      (idx_i),
      .srch_i     (srch_i),
      .left_i     (left_w),
      .right_i    (right_w),
      .ent_o      (ent[j]),
      .cand_i     (cin_w),
      .cand_idx_i (ciin_w),
      .cand_o     (cand[j]),
      .cand_idx_o (cidx[j])
    );
  end

  assign cand_o     = cand[MAX_BLOCKS-1];
  assign cand_idx_o = cidx[MAX_BLOCKS-1];

endmodule

FILE: rtl/core/fit_policy_block_allocator.sv
// flow: a request is taken in the idle state, the search wave then walks the row of
//   block cells one cell per cycle, and the result is written once the output slot is
//   free of a result still waiting on m_axis_tready; a free that also merges with the
//   block below it adds a merge state; a new request is taken only when idle
// reset: one free block over the whole arena, first fit, no result pending
module fit_policy_block_allocator #(
  parameter int unsigned ARENA_BYTES  = fpba_pkg::DEF_ARENA_BYTES,
  parameter int unsigned HEADER_BYTES = fpba_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_BLOCKS   = fpba_pkg::DEF_MAX_BLOCKS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // req_size[12:0], free_addr[24:13]
  input  logic [0:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result_status[1:0], result_addr[13:2], result_size[26:14]
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);
  import fpba_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned RA0 = (ARENA_RST > ARENA_BYTES) ? ARENA_BYTES : ARENA_RST;
  localparam int unsigned RA1 = (RA0 < ARENA_MIN) ? ARENA_MIN : RA0;
  localparam int unsigned RA2 = (RA1 < HEADER_BYTES) ? HEADER_BYTES : RA1;
  localparam int unsigned RST_SIZE = RA2 - HEADER_BYTES;
  localparam logic [DW-1:0] HDR = DW'(HEADER_BYTES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_MERGE = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [IW-1:0] scnt_q, scnt_d;
  logic [IW-1:0] midx_q, midx_d;
  logic [CW-1:0] bcnt_q, bcnt_d;
  logic [1:0]    policy_q, policy_d;
  srch_t         srch_q, srch_d;
  logic          mval_q, mval_d;
  logic [31:0]   mdat_q, mdat_d;

  cmd_t          cmd;
  logic [IW-1:0] cidx;
  srch_t         srch;
  cand_t         cand;
  logic [IW-1:0] cand_idx;
  logic [DW-1:0] eff;
  logic          slot_free, split;
  logic [DW+1:0] split_lim;
  logic [AWF-1:0] raddr;

  assign s_axis_tready = (state_q == S_IDLE) && !cfg_we_i;
  assign slot_free     = !mval_q || m_axis_tready;

  always_comb begin
    srch        = srch_q;
    srch.policy = policy_q;
  end

  always_comb begin
    eff = (32'(cfg_data_i) > ARENA_BYTES) ? DW'(ARENA_BYTES) : cfg_data_i;
    if (eff < DW'(ARENA_MIN)) eff = DW'(ARENA_MIN);
    if (eff < HDR) eff = HDR;
  end

  assign split_lim = {2'b00, srch_q.need[DW-1:0]} + {2'b00, HDR};
  assign split     = ({2'b00, cand.size} > split_lim) && (bcnt_q < CW'(MAX_BLOCKS));
  assign raddr     = AWF'(cand.off + HDR);

  always_comb begin
    state_d   = state_q;
    scnt_d    = scnt_q;
    midx_d    = midx_q;
    bcnt_d    = bcnt_q;
    policy_d  = policy_q;
    srch_d    = srch_q;
    mval_d    = mval_q && !m_axis_tready;
    mdat_d    = mdat_q;
    cmd       = '0;
    cmd.op    = OP_NONE;
    cidx      = cand_idx;

    case (state_q)
      S_IDLE: begin
        if (cfg_we_i) begin
          if (cfg_idx_i == CFG_POLICY) begin
            policy_d = cfg_data_i[1:0];
          end else begin
            cmd.op        = OP_INIT;
            cmd.init_size = eff - HDR;
            bcnt_d        = CW'(1);
          end
        end else if (s_axis_tvalid) begin
          srch_d.mode_free = s_axis_tuser[0];
          srch_d.need      = ({1'b0, s_axis_tdata[12:0]} + (DW+1)'(7)) & ~(DW+1)'(7);
          srch_d.addr      = s_axis_tdata[24:13];
          scnt_d           = '0;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        scnt_d = scnt_q + 1'b1;
        if (scnt_q == IW'(MAX_BLOCKS - 1)) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (slot_free) begin
          mval_d  = 1'b1;
          state_d = S_IDLE;
          if (srch_q.mode_free) begin
            if (!cand.v || cand.free) begin
              mdat_d = {5'b0, DW'(0), srch_q.addr, ST_BADFREE};
            end else begin
              mdat_d    = {5'b0, cand.size, srch_q.addr, ST_OK};
              cmd.op    = OP_FREE;
              cmd.merge = cand.nf;
              bcnt_d    = bcnt_q - CW'(cand.nf);
              midx_d    = cand_idx;
              if (cand.pf) state_d = S_MERGE;
            end
          end else if (srch_q.need == '0) begin
            mdat_d = {5'b0, DW'(0), AWF'(0), ST_ZERO};
          end else if (!cand.v) begin
            mdat_d = {5'b0, DW'(0), AWF'(0), ST_NOFIT};
          end else begin
            mdat_d    = {5'b0, srch_q.need[DW-1:0], raddr, ST_OK};
            cmd.op    = OP_ALLOC;
            cmd.need  = srch_q.need[DW-1:0];
            cmd.split = split;
            bcnt_d    = bcnt_q + CW'(split);
          end
        end
      end
      S_MERGE: begin
        cmd.op  = OP_MERGE;
        cidx    = midx_q;
        bcnt_d  = bcnt_q - 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      scnt_q   <= '0;
      bcnt_q   <= CW'(1);
      policy_q <= FIT_FIRST;
      mval_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      scnt_q   <= scnt_d;
      bcnt_q   <= bcnt_d;
      policy_q <= policy_d;
      mval_q   <= mval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    srch_q <= srch_d;
    midx_q <= midx_d;
    mdat_q <= mdat_d;
  end

  fpba_chain #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES),
    .RST_SIZE     (RST_SIZE),
    .IW           (IW)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .idx_i      (cidx),
    .srch_i     (srch),
    .cand_o     (cand),
    .cand_idx_o (cand_idx)
  );

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdat_q;

  a_bcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q != '0 && bcnt_q <= CW'(MAX_BLOCKS))
    else $error("block count out of range");

  a_merge_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MERGE |-> midx_q != '0)
    else $error("left merge on first block");

  a_eval_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && mval_q && !m_axis_tready) |=> (state_q == S_EVAL && mval_q))
    else $error("pending result overwritten");

endmodule

FILE: test/fit_policy_block_allocator_tb.sv
module fit_policy_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpba_pkg::*;

  localparam int unsigned ARENA_MAX = 4096;
  localparam int unsigned HDR = 32;
  localparam int unsigned NBLK = 128;
  localparam int unsigned LAT = NBLK + 8;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic [12:0] size;
    logic [11:0] addr;
    logic [1:0]  status;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // req_size[12:0], free_addr[24:13]
  logic [0:0]  s_axis_tuser = '0;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // result_status[1:0], result_addr[13:2], result_size[26:14]
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;

  fit_policy_block_allocator dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow heap
  int unsigned blk_off[NBLK];
  int unsigned blk_size[NBLK];
  bit          blk_free[NBLK];
  int unsigned blk_count;
  logic [1:0]  policy;

  grant_t      pending_grants[$];
  int unsigned live_addrs[$];
  int          failures = 0;
  longint unsigned cycles = 0;

  function automatic void shadow_format(int unsigned bytes);
    int unsigned eff;
    eff = bytes;
    if (eff > ARENA_MAX) eff = ARENA_MAX;
    if (eff < ARENA_MIN) eff = ARENA_MIN;
    if (eff < HDR) eff = HDR;
    blk_off[0] = 0;
    blk_size[0] = eff - HDR;
    blk_free[0] = 1'b1;
    blk_count = 1;
  endfunction

  function automatic void drop_block(int unsigned i);
    for (int unsigned k = i; k + 1 < blk_count; k++) begin
      blk_off[k] = blk_off[k+1];
      blk_size[k] = blk_size[k+1];
      blk_free[k] = blk_free[k+1];
    end
    blk_count--;
  endfunction

  function automatic grant_t heap_request(bit is_free, int unsigned req, int unsigned faddr);
    grant_t g;
    int unsigned need, pick, i;
    g = '0;
    if (!is_free) begin
      if (req == 0) begin
        g.status = ST_ZERO;
      end else begin
        need = (req + 7) & ~32'd7;
        pick = blk_count;
        for (i = 0; i < blk_count; i++) begin
          if (!blk_free[i] || blk_size[i] < need) continue;
          if (policy == FIT_FIRST) begin
            pick = i;
            break;
          end else if (policy == FIT_BEST) begin
            if (pick == blk_count || blk_size[i] < blk_size[pick]) pick = i;
          end else if (policy == FIT_WORST) begin
            if (pick == blk_count || blk_size[i] > blk_size[pick]) pick = i;
          end
        end
        if (pick >= blk_count) begin
          g.status = ST_NOFIT;
        end else begin
          if (blk_size[pick] > need + HDR && blk_count < NBLK) begin
            for (int unsigned k = blk_count; k > pick + 1; k--) begin
              blk_off[k] = blk_off[k-1];
              blk_size[k] = blk_size[k-1];
              blk_free[k] = blk_free[k-1];
            end
            blk_off[pick+1] = blk_off[pick] + HDR + need;
            blk_size[pick+1] = blk_size[pick] - need - HDR;
            blk_free[pick+1] = 1'b1;
            blk_size[pick] = need;
            blk_count++;
          end
          blk_free[pick] = 1'b0;
          g.status = ST_OK;
          g.addr = 12'(blk_off[pick] + HDR);
          g.size = 13'(need);
          live_addrs.push_back(blk_off[pick] + HDR);
        end
      end
    end else begin
      g.addr = 12'(faddr);
      for (i = 0; i < blk_count; i++)
        if (blk_off[i] + HDR == faddr) break;
      if (i >= blk_count || blk_free[i]) begin
        g.status = ST_BADFREE;
      end else begin
        g.status = ST_OK;
        g.size = 13'(blk_size[i]);
        blk_free[i] = 1'b1;
        if (i + 1 < blk_count && blk_free[i+1]) begin
          blk_size[i] += HDR + blk_size[i+1];
          drop_block(i + 1);
        end
        if (i > 0 && blk_free[i-1]) begin
          blk_size[i-1] += HDR + blk_size[i];
          drop_block(i);
        end
      end
    end
    return g;
  endfunction

  task automatic send_request(bit is_free, int unsigned req, int unsigned faddr);
    int unsigned w;
    w = $urandom_range(0, 8);
    if (w != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (w) @(negedge clk_i);
    end
    s_axis_tuser <= is_free;
    s_axis_tdata <= {7'd0, faddr[11:0], req[12:0]};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_grants.push_back(heap_request(is_free, req[12:0], faddr[11:0]));
    @(negedge clk_i);
  endtask

  task automatic alloc(int unsigned req);
    send_request(1'b0, req, $urandom_range(0, 4095));
  endtask

  task automatic release_addr(int unsigned a);
    send_request(1'b1, $urandom_range(0, 8191), a);
  endtask

  task automatic release_random_live();
    int unsigned j;
    if (live_addrs.size() == 0) begin
      release_addr($urandom_range(0, 4095));
    end else begin
      j = $urandom_range(0, live_addrs.size() - 1);
      release_addr(live_addrs[j]);
      live_addrs.delete(j);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(negedge clk_i);
    repeat (LAT) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, int unsigned val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[12:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_POLICY) begin
      policy = val[1:0];
    end else begin
      shadow_format(val[12:0]);
      live_addrs.delete();
    end
  endtask

  task automatic test_zero_and_extremes();
    alloc(0);
    alloc(8191);
    alloc(4064);
    release_addr(32);
    release_addr(32);
    release_addr(0);
    release_addr(4095);
    alloc(1);
    alloc(7);
    alloc(9);
    release_addr(32);
    release_addr(48);
  endtask

  task automatic test_policies();
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_POLICY, p);
      write_reg(CFG_ARENA, 1024);
      alloc(100); alloc(16); alloc(200); alloc(16); alloc(40); alloc(16);
      release_addr(32);
      release_addr(32 + 104 + 48 + 32);
      alloc(24);
      alloc(8);
    end
  endtask

  task automatic test_arena_sizes();
    write_reg(CFG_POLICY, FIT_FIRST);
    write_reg(CFG_ARENA, 0);
    alloc(32); alloc(24); alloc(1);
    write_reg(CFG_ARENA, 8191);
    alloc(4064);
    write_reg(CFG_ARENA, 64);
    alloc(8); alloc(8);
  endtask

  task automatic test_full_table();
    write_reg(CFG_ARENA, 4096);
    for (int n = 0; n < 130; n++) alloc(1);
    release_addr(32 + 40 * 5);
    release_addr(32 + 40 * 6);
    release_addr(32 + 40 * 4);
  endtask

  task automatic test_random(int unsigned n);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 150 == 0) begin
        write_reg(CFG_POLICY, $urandom_range(0, 3));
        write_reg(CFG_ARENA, $urandom_range(0, 8191));
      end
      if (k == n / 2) drain();
      r = $urandom_range(0, 99);
      if (r < 50) alloc($urandom_range(0, 9) == 0 ? $urandom_range(0, 8191)
                                                 : $urandom_range(1, 200));
      else if (r < 90) release_random_live();
      else release_addr($urandom_range(0, 4095));
    end
  endtask

  always @(posedge clk_i) begin
    grant_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[26:0];
      if (pending_grants.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata);
        failures++;
      end else begin
        want = pending_grants.pop_front();
        if (got.status !== want.status) begin
          $error("result_status expected %0d actual %0d", want.status, got.status);
          failures++;
        end
        if (got.addr !== want.addr) begin
          $error("result_addr expected %0d actual %0d", want.addr, got.addr);
          failures++;
        end
        if (got.size !== want.size) begin
          $error("result_size expected %0d actual %0d", want.size, got.size);
          failures++;
        end
      end
    end
  end

  initial begin
    int unsigned w;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        w = $urandom_range(0, 8);
        if (w != 0) begin
          m_axis_tready <= 1'b0;
          repeat (w) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    policy = FIT_FIRST;
    shadow_format(ARENA_RST);
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_zero_and_extremes();
    test_policies();
    test_arena_sizes();
    test_full_table();
    test_random(550);
    drain();
    if (failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: files.f
rtl/core/fpba_pkg.sv
rtl/core/fpba_cell.sv
rtl/core/fpba_chain.sv
rtl/core/fit_policy_block_allocator.sv
test/fit_policy_block_allocator_tb.sv
